// File: design/pfr_pkg.sv
// Shared types and constants for the page frame replacement block.
`default_nettype none

package pfr_pkg;

  // Fixed field widths of the stream and configuration ports
  localparam int unsigned PageNumW  = 16;
  localparam int unsigned FrameIdxW = 4;
  localparam int unsigned FaultOutW = 16;
  localparam int unsigned FramesW   = 5;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned CfgAddrW  = 1;

  // Padded stream widths (tdata in whole bytes)
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned OutTuserW = 2;

  localparam logic [FramesW-1:0] FramesReset = 5'd16;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_POLICY = 1'b0,
    CFG_FRAMES = 1'b1
  } cfg_idx_e;

  // Replacement policy
  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_e;

  // Frame store update command
  typedef struct packed {
    logic en;     // apply an update this cycle
    logic clear;  // start of sequence: drop all frames and ranks first
    logic load;   // miss: load the page into the touched frame
  } pfr_upd_t;

endpackage : pfr_pkg

`default_nettype wire

// File: design/page_frame_replacement.sv
// Top level of the page frame replacement block (FIFO and LRU policies).
//
//  Channel   Direction  Signals                                  Payload
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser          page reference
//  m_axis    out        m_axis_tvalid/tready/tdata/tuser          lookup result
//  cfg       in         cfg_valid_i/cfg_ready_o/cfg_addr_i/data   policy, frame count
//
// One reference per cycle sustained while the output is not stalled; the input transfer
// loads the input register, then one pass of compare, victim select and update loads
// the result register. Frame state is read and written in that single pass.
// Reset clears valid bits, ranks, FIFO pointer, fault count and sets the policy
// to FIFO with 16 frames; page tags stay unknown until loaded.
// An output stall holds the result register and backs up through the input register.
`default_nettype none

module page_frame_replacement
  import pfr_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0: page_number[15:0]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // Fields from bit 0: start_of_sequence
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: frame_index[3:0], evicted_page[19:4], fault_count[35:20], zero pad
  output logic [OutTdataW-1:0] m_axis_tdata,
  // Fields from bit 0: is_hit, evicted_valid
  output logic [OutTuserW-1:0] m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned NP    = 1 << IDX_W;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // Configuration registers
  policy_e             policy_q;
  logic [FramesW-1:0]  frames_q;

  // Input register
  logic                 in_valid_q;
  logic [PAGE_BITS-1:0] in_page_q;
  logic                 in_sos_q;

  // Sequence state
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [COUNT_BITS-1:0] faults_q, faults_d;

  // Result register
  logic                 out_valid_q;
  logic                 out_hit_q;
  logic                 out_ev_valid_q;
  logic [FrameIdxW-1:0] out_idx_q;
  logic [PageNumW-1:0]  out_ev_page_q;
  logic [FaultOutW-1:0] out_faults_q;

  logic advance;

  // Store and search signals
  pfr_upd_t             upd;
  logic                 match     [NUM_FRAMES];
  logic                 match_in_use [NUM_FRAMES];
  logic                 valid     [NUM_FRAMES];
  logic [IDX_W-1:0]     rank      [NUM_FRAMES];
  logic                 in_use    [NUM_FRAMES];
  logic                 empty     [NUM_FRAMES];
  logic                 in_use_pad[NP];
  logic [0:0]           zero_key  [NUM_FRAMES];
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 empty_found;
  logic [IDX_W-1:0]     empty_idx;
  logic                 lru_found;
  logic [IDX_W-1:0]     lru_idx;
  logic [IDX_W-1:0]     victim;
  logic [IDX_W-1:0]     touch_idx;
  logic [PAGE_BITS-1:0] touch_page;
  logic [IDX_W-1:0]     ptr_base, ptr_use, ptr_next;
  logic [IDX_W:0]       ptr_inc;
  logic                 ptr_wrap;
  logic [COUNT_BITS-1:0] faults_base;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIFO;
      frames_q <= FramesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_POLICY: policy_q <= policy_e'(cfg_data_i[0]);
        CFG_FRAMES: frames_q <= cfg_data_i;
      endcase
    end
  end

  // Advance when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_page_q <= PAGE_BITS'(s_axis_tdata[PageNumW-1:0]);
      in_sos_q  <= s_axis_tuser;
    end
  end

  // Frames taking part: a count of zero acts as one
  for (genvar f = 0; f < NP; f++) begin : g_use
    if (f < NUM_FRAMES) begin : g_real
      assign in_use[f]     = (frames_q == '0) ? (f == 0) : (32'(f) < 32'(frames_q));
      assign in_use_pad[f] = in_use[f];
      assign empty[f]      = in_use[f] && !valid[f];
      assign zero_key[f]   = 1'b0;
    end else begin : g_pad
      assign in_use_pad[f] = 1'b0;
    end
  end

  // Hit search, first empty frame, least recently used frame
  for (genvar f = 0; f < NUM_FRAMES; f++) begin : g_mu
    assign match_in_use[f] = match[f] && in_use[f];
  end

  pfr_pick #(.N(NUM_FRAMES), .IDX_W(IDX_W), .KEY_W(1)) u_hit_pick (
    .ok_i    (match_in_use),
    .key_i   (zero_key),
    .found_o (hit),
    .idx_o   (hit_idx)
  );

  pfr_pick #(.N(NUM_FRAMES), .IDX_W(IDX_W), .KEY_W(1)) u_empty_pick (
    .ok_i    (empty),
    .key_i   (zero_key),
    .found_o (empty_found),
    .idx_o   (empty_idx)
  );

  pfr_pick #(.N(NUM_FRAMES), .IDX_W(IDX_W), .KEY_W(IDX_W)) u_lru_pick (
    .ok_i    (in_use),
    .key_i   (rank),
    .found_o (lru_found),
    .idx_o   (lru_idx)
  );

  // FIFO pointer: wrap before use and after advance
  always_comb begin
    ptr_base = in_sos_q ? '0 : ptr_q;
    ptr_use  = in_use_pad[ptr_base] ? ptr_base : '0;
    ptr_inc  = {1'b0, ptr_use} + 1'b1;
    ptr_wrap = ptr_inc[IDX_W] | ~in_use_pad[ptr_inc[IDX_W-1:0]];
    ptr_next = ptr_wrap ? '0 : ptr_inc[IDX_W-1:0];
  end

  // Pick the victim frame
  always_comb begin
    if (policy_q == POLICY_LRU) begin
      victim = empty_found ? empty_idx : (lru_found ? lru_idx : '0);
    end else begin
      victim = ptr_use;
    end
    touch_idx = hit ? hit_idx : victim;
  end

  // Sequence state update
  always_comb begin
    faults_base = in_sos_q ? '0 : faults_q;
    faults_d    = faults_q;
    ptr_d       = ptr_q;
    if (advance) begin
      faults_d = (!hit && (faults_base != CountMax)) ? faults_base + 1'b1 : faults_base;
      ptr_d    = (!hit && (policy_q == POLICY_FIFO)) ? ptr_next : ptr_base;
    end
  end

  assign upd.en    = advance;
  assign upd.clear = in_sos_q;
  assign upd.load  = !hit;

  pfr_frame_store #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (upd),
    .page_i       (in_page_q),
    .touch_idx_i  (touch_idx),
    .match_o      (match),
    .valid_o      (valid),
    .rank_o       (rank),
    .touch_page_o (touch_page)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      faults_q <= '0;
    end else begin
      ptr_q    <= ptr_d;
      faults_q <= faults_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q      <= hit;
      out_idx_q      <= FrameIdxW'(touch_idx);
      out_ev_valid_q <= !hit && valid[touch_idx];
      out_ev_page_q  <= (!hit && valid[touch_idx]) ? PageNumW'(touch_page) : '0;
      out_faults_q   <= FaultOutW'(faults_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_faults_q, out_ev_page_q, out_idx_q});
  assign m_axis_tuser  = {out_ev_valid_q, out_hit_q};

  // A hit never reports an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_ev_valid_q))
    else $error("hit reported with an evicted page");

  // The FIFO pointer stays inside the frame set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < 32'(NUM_FRAMES))
    else $error("FIFO pointer beyond frame count");

  // A sequence start always faults once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_sos_q) |=> (out_faults_q == FaultOutW'(1)) && !out_hit_q)
    else $error("sequence start did not count one fault");

  // A hit leaves the fault count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && hit && !in_sos_q) |=> (faults_q == $past(faults_q)))
    else $error("fault count moved on a hit");

endmodule : page_frame_replacement

`default_nettype wire

// File: design/pfr_pick.sv
// Registered-free selection tree: picks the eligible entry with the largest key,
// lowest index on a tie.
`default_nettype none

module pfr_pick #(
  parameter int unsigned N     = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned KEY_W = 4
) (
  input  logic             ok_i  [N],
  input  logic [KEY_W-1:0] key_i [N],
  output logic             found_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam int unsigned NP = 1 << IDX_W;

  // Heap-ordered tree nodes, leaves at NP..2*NP-1
  logic             node_ok  [1:2*NP-1];
  logic [KEY_W-1:0] node_key [1:2*NP-1];
  logic [IDX_W-1:0] node_idx [1:2*NP-1];

  // Fill the leaves, padding beyond N is never eligible
  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < N) begin : g_real
      assign node_ok[NP+i]  = ok_i[i];
      assign node_key[NP+i] = key_i[i];
    end else begin : g_pad
      assign node_ok[NP+i]  = 1'b0;
      assign node_key[NP+i] = '0;
    end
    assign node_idx[NP+i] = IDX_W'(i);
  end

  // Combine pairs, left side wins on equal keys
  for (genvar n = 1; n < NP; n++) begin : g_node
    logic take_l;
    assign take_l = node_ok[2*n] &&
                    (!node_ok[2*n+1] || (node_key[2*n] >= node_key[2*n+1]));
    assign node_ok[n]  = node_ok[2*n] | node_ok[2*n+1];
    assign node_key[n] = take_l ? node_key[2*n] : node_key[2*n+1];
    assign node_idx[n] = take_l ? node_idx[2*n] : node_idx[2*n+1];
  end

  assign found_o = node_ok[1];
  assign idx_o   = node_idx[1];

endmodule : pfr_pick

`default_nettype wire

// File: design/pfr_frame_store.sv
// Page frame store: page tags, valid bits and recency ranks with their update.
`default_nettype none

module pfr_frame_store
  import pfr_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfr_upd_t             upd_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [IDX_W-1:0]     touch_idx_i,
  output logic                 match_o     [NUM_FRAMES],
  output logic                 valid_o     [NUM_FRAMES],
  output logic [IDX_W-1:0]     rank_o      [NUM_FRAMES],
  output logic [PAGE_BITS-1:0] touch_page_o
);

  localparam logic [IDX_W-1:0] RankMax = IDX_W'(NUM_FRAMES - 1);

  logic [PAGE_BITS-1:0] page_q  [NUM_FRAMES];
  logic                 valid_q [NUM_FRAMES];
  logic [IDX_W-1:0]     rank_q  [NUM_FRAMES];
  logic [IDX_W-1:0]     old_rank;

  // Rank of the touched frame before this reference
  assign old_rank     = rank_o[touch_idx_i];
  assign touch_page_o = page_q[touch_idx_i];

  for (genvar f = 0; f < NUM_FRAMES; f++) begin : g_frame
    logic             is_touch;
    logic             bump;
    logic             valid_d;
    logic [IDX_W-1:0] rank_d;

    // View the frame as cleared when a sequence starts
    assign valid_o[f] = valid_q[f] & ~upd_i.clear;
    assign rank_o[f]  = upd_i.clear ? '0 : rank_q[f];
    assign match_o[f] = valid_o[f] && (page_q[f] == page_i);

    // Age frames that were more recent than the touched one, or all other valid frames on a load
    assign is_touch = (touch_idx_i == IDX_W'(f));
    assign bump     = valid_o[f] && !is_touch && (rank_o[f] != RankMax) &&
                      (upd_i.load || (rank_o[f] < old_rank));
    assign rank_d   = is_touch ? '0 : (bump ? rank_o[f] + 1'b1 : rank_o[f]);
    assign valid_d  = valid_o[f] | (is_touch & upd_i.load);

    // Hold valid and rank state
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[f] <= 1'b0;
        rank_q[f]  <= '0;
      end else if (upd_i.en) begin
        valid_q[f] <= valid_d;
        rank_q[f]  <= rank_d;
      end
    end

    // Load the page tag on a miss
    always_ff @(posedge clk_i) begin
      if (upd_i.en && upd_i.load && is_touch) begin
        page_q[f] <= page_i;
      end
    end
  end

endmodule : pfr_frame_store

`default_nettype wire

// File: sim/tb_page_frame_replacement.sv
// Self-checking testbench for the page frame replacement block.
module tb_page_frame_replacement
  import pfr_pkg::*;
();

  localparam int unsigned Frames     = 16;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned CycleRefs  = 34;

  // One page reference as it travels on the input stream
  typedef struct packed {
    logic [PageNumW-1:0] page;
    logic                start;
  } page_ref_t;

  // Expected outcome of one reference
  typedef struct packed {
    logic                 is_hit;
    logic [FrameIdxW-1:0] frame;
    logic                 ev_valid;
    logic [PageNumW-1:0]  ev_page;
    logic [FaultOutW-1:0] faults;
  } lookup_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // page_number[15:0]
  logic                 s_axis_tuser  = 1'b0; // start_of_sequence
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;  // frame_index, evicted_page, fault_count, pad
  logic [OutTuserW-1:0] m_axis_tuser;  // is_hit, evicted_valid
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i    = CFG_POLICY;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  page_frame_replacement i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the frame set and its settings
  policy_e            cur_policy = POLICY_FIFO;
  logic [FramesW-1:0] cur_frames = FramesReset;
  bit [PageNumW-1:0]  frame_tag  [Frames];
  bit                 frame_live [Frames];
  bit [3:0]           frame_age  [Frames];
  int unsigned        rr_ptr     = 0;
  bit [FaultOutW-1:0] fault_tally = '0;

  page_ref_t   pending_q [$];
  lookup_t     outcome_q [$];
  page_ref_t   cur_ref   = '0;
  bit          drv_busy  = 1'b0;
  int unsigned drv_gap   = 0;
  int unsigned mon_wait  = 0;
  bit          calm      = 1'b0;
  lookup_t     want;
  int unsigned n_refs = 0, n_hits = 0, n_evicts = 0, n_errors = 0;
  int unsigned cycles = 0;

  // Make frame f the most recent; younger valid frames (all of them on a load) age by one
  function automatic void promote(int unsigned f, bit loaded);
    bit [3:0] old;
    int unsigned g;
    old = frame_age[f];
    for (g = 0; g < Frames; g++) begin
      if (g != f && frame_live[g] && (loaded || frame_age[g] < old) &&
          frame_age[g] != 4'(Frames - 1))
        frame_age[g]++;
    end
    frame_age[f] = '0;
  endfunction

  // Look up one reference, update the shadow and return what the block must report
  function automatic lookup_t resolve_reference(page_ref_t r);
    lookup_t     res;
    int unsigned used, victim, best, f;
    bit          hit, found;
    res = '0;
    hit = 1'b0;
    found = 1'b0;
    victim = 0;
    best = 0;
    if (r.start) begin
      for (f = 0; f < Frames; f++) begin
        frame_live[f] = 1'b0;
        frame_age[f] = '0;
      end
      rr_ptr = 0;
      fault_tally = '0;
    end
    used = (cur_frames == 0) ? 1 : (cur_frames > Frames) ? Frames : cur_frames;
    for (f = 0; f < used && !hit; f++) begin
      if (frame_live[f] && frame_tag[f] == r.page) begin
        hit = 1'b1;
        victim = f;
      end
    end
    if (hit) begin
      promote(victim, 1'b0);
    end else begin
      if (cur_policy == POLICY_FIFO) begin
        if (rr_ptr >= used) rr_ptr = 0;
        victim = rr_ptr;
        rr_ptr = (rr_ptr + 1 >= used) ? 0 : rr_ptr + 1;
      end else begin
        // empty frame first, else the oldest, lowest index on a tie
        for (f = 0; f < used && !found; f++) begin
          if (!frame_live[f]) begin
            victim = f;
            found = 1'b1;
          end
        end
        if (!found) begin
          for (f = 0; f < used; f++) begin
            if (f == 0 || frame_age[f] > best) begin
              best = frame_age[f];
              victim = f;
            end
          end
        end
      end
      if (frame_live[victim]) begin
        res.ev_valid = 1'b1;
        res.ev_page = frame_tag[victim];
      end
      frame_tag[victim] = r.page;
      frame_live[victim] = 1'b1;
      promote(victim, 1'b1);
      if (fault_tally != '1) fault_tally++;
    end
    res.is_hit = hit;
    res.frame = FrameIdxW'(victim);
    res.faults = fault_tally;
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // Driver: present queued references, predict each one on its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(resolve_reference(cur_ref));
        n_refs++;
        drv_busy = 1'b0;
        drv_gap = calm ? 0 : $urandom_range(0, 6);
      end
      if (!drv_busy) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (pending_q.size() != 0) begin
          cur_ref = pending_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      s_axis_tvalid <= drv_busy;
      s_axis_tdata <= cur_ref.page;
      s_axis_tuser <= cur_ref.start;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no reference outstanding");
          n_errors++;
        end else begin
          want = outcome_q.pop_front();
          if (want.is_hit) n_hits++;
          if (want.ev_valid) n_evicts++;
          check_field("is_hit", 16'(want.is_hit), 16'(m_axis_tuser[0]));
          check_field("evicted_valid", 16'(want.ev_valid), 16'(m_axis_tuser[1]));
          check_field("frame_index", 16'(want.frame), 16'(m_axis_tdata[3:0]));
          check_field("evicted_page", want.ev_page, m_axis_tdata[19:4]);
          check_field("fault_count", want.faults, m_axis_tdata[35:20]);
        end
        mon_wait = calm ? 0 : $urandom_range(0, 6);
      end else if (mon_wait != 0) begin
        mon_wait--;
      end
      m_axis_tready <= (mon_wait == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_page_frame_replacement: FAIL");
      $finish;
    end
  end

  task automatic push_ref(logic [PageNumW-1:0] page, bit start);
    page_ref_t r;
    r.page = page;
    r.start = start;
    pending_q.push_back(r);
  endtask

  // Write one register and mirror it once the transfer is seen
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_POLICY) cur_policy = policy_e'(val[0]);
    else cur_frames = val;
  endtask

  // Hold off until every queued reference has come back
  task automatic drain();
    while (pending_q.size() != 0 || drv_busy || outcome_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  logic [FramesW-1:0] frame_plan [10] = '{5'd16, 5'd1, 5'd4, 5'd8, 5'd0,
                                          5'd2, 5'd31, 5'd16, 5'd3, 5'd12};

  initial begin : stimulus
    int unsigned       ph, k, span;
    logic [PageNumW-1:0] base, pg;
    bit                st;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (FIFO, 16 frames): page extremes, hits after misses
    push_ref(16'h0000, 1'b1);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h0000, 1'b0);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'hAAAA, 1'b0);
    push_ref(16'h5555, 1'b0);
    drain();

    // LRU over two frames: empty frame first, then the least recent one
    write_reg(CFG_POLICY, {4'b0000, POLICY_LRU});
    write_reg(CFG_FRAMES, 5'd2);
    push_ref(16'h0001, 1'b1);
    push_ref(16'h0002, 1'b0);
    push_ref(16'h0001, 1'b0);
    push_ref(16'h0003, 1'b0);
    push_ref(16'h0001, 1'b0);
    push_ref(16'h0004, 1'b0);
    drain();

    // FIFO with a zero frame count, which acts as one frame
    write_reg(CFG_POLICY, {4'b1111, POLICY_FIFO});
    write_reg(CFG_FRAMES, 5'd0);
    push_ref(16'h0010, 1'b1);
    push_ref(16'h0011, 1'b0);
    push_ref(16'h0011, 1'b0);
    drain();

    // Over-range count acts as 16; then shrink so the pointer wraps to 0
    write_reg(CFG_FRAMES, 5'd31);
    for (k = 0; k < 5; k++) push_ref(16'h0100 + 16'(k), k == 0);
    drain();
    write_reg(CFG_FRAMES, 5'd3);
    push_ref(16'h0104, 1'b0);
    push_ref(16'h0102, 1'b0);
    drain();

    // Random phases: mostly references into a small working set
    for (ph = 0; ph < 10; ph++) begin
      calm = (ph % 3 == 2);
      write_reg(CFG_POLICY, {4'($urandom), (ph % 2 == 1) ? POLICY_LRU : POLICY_FIFO});
      write_reg(CFG_FRAMES, frame_plan[ph]);
      base = 16'($urandom);
      span = $urandom_range(1, 20);
      for (k = 0; k < 70; k++) begin
        st = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
        if (st && $urandom_range(0, 1) == 1) begin
          base = 16'($urandom);
          span = $urandom_range(1, 20);
        end
        if ($urandom_range(0, 9) == 0) pg = 16'($urandom);
        else pg = base + 16'($urandom_range(0, span));
        push_ref(pg, st);
      end
      drain();
    end

    // Cyclic misses over one more page than frames, then a fresh sequence
    calm = 1'b1;
    write_reg(CFG_POLICY, {4'b0000, POLICY_FIFO});
    write_reg(CFG_FRAMES, 5'd16);
    for (k = 0; k < CycleRefs; k++) push_ref(16'(k % 17), k == 0);
    push_ref(16'h0005, 1'b1);
    drain();
    calm = 1'b0;
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d references (%0d hits, %0d evictions) in FIFO and LRU mode,",
             n_refs, n_hits, n_evicts);
    $display("frame counts 0 to 31, frame shrink, cyclic misses and sequence restarts.");
    if (n_errors == 0) $display("tb_page_frame_replacement: PASS");
    else $display("tb_page_frame_replacement: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/pfr_pkg.sv
design/pfr_pick.sv
design/pfr_frame_store.sv
design/page_frame_replacement.sv
sim/tb_page_frame_replacement.sv
